>>> rtl/core/tkri_pkg.sv
`timescale 1ns / 1ps

package tkri_pkg;

	// default list depth
	localparam int LIST_DEPTH = 10;

	// field widths
	localparam int ID_W   = 16;
	localparam int PTS_W  = 16;
	localparam int STP_W  = 16;
	localparam int RANK_W = 4;

	// one stored list entry
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PTS_W-1:0] pts;
		logic [STP_W-1:0] stp;
	} entry_t;

	// controller to datapath commands
	typedef struct packed {
		logic ins;   // insert the incoming entry, restart listing
		logic adv;   // listing transaction taken, step to next rank
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last;  // the rank now presented is the final occupied one
	} status_t;

endpackage

>>> rtl/core/tkri_ifs.sv
`timescale 1ns / 1ps

// input channel: one entry to insert
interface tkri_in_if;
	logic                          valid;
	logic                          ready;
	logic [tkri_pkg::ID_W-1:0]     player_id;
	logic [tkri_pkg::PTS_W-1:0]    points;
	logic [tkri_pkg::STP_W-1:0]    steps;

	modport source (output valid, output player_id, output points, output steps,
		input ready);
	modport sink (input valid, input player_id, input points, input steps,
		output ready);
endinterface

// output channel: one ranked entry of the listing
interface tkri_out_if;
	logic                          valid;
	logic                          ready;
	logic [tkri_pkg::RANK_W-1:0]   rank;
	logic [tkri_pkg::ID_W-1:0]     entry_id;
	logic [tkri_pkg::PTS_W-1:0]    entry_points;
	logic [tkri_pkg::STP_W-1:0]    entry_steps;
	logic                          last;

	modport source (output valid, output rank, output entry_id, output entry_points,
		output entry_steps, output last, input ready);
	modport sink (input valid, input rank, input entry_id, input entry_points,
		input entry_steps, input last, output ready);
endinterface

>>> rtl/core/top_k_ranked_insert_core.sv
`timescale 1ns / 1ps

// ranked list of up to LIST_DEPTH entries (id, points, steps), best first.
// in_ch carries one entry per transaction; it is placed by points, then
// steps, both higher first, below any exact tie; a full list drops its
// lowest entry (the new one if it ranks last).
// after each insert, out_ch carries the whole list, one transaction per
// occupied rank starting at rank 0, with last set on the final rank.
// in_ch.ready is high only while no listing is in progress: the insert
// happens at the accepting edge, the first listing transaction is offered
// on the next cycle, and the block takes the next entry the cycle after the
// last listing transaction. the single output port reads one rank per
// cycle while out_ch does not stall, as the occupied cells rotate past
// the head cell.
// when the receiver stalls, the current listing transaction holds steady.
// reset empties the list and returns to waiting for an entry.
module top_k_ranked_insert_core #(
	parameter int LIST_DEPTH = tkri_pkg::LIST_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	tkri_in_if.sink   in_ch,
	tkri_out_if.source out_ch
);

	tkri_pkg::cmd_t    cmd;
	tkri_pkg::status_t status;

	tkri_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	tkri_dp #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.player_id    (in_ch.player_id),
		.points       (in_ch.points),
		.steps        (in_ch.steps),
		.rank         (out_ch.rank),
		.entry_id     (out_ch.entry_id),
		.entry_points (out_ch.entry_points),
		.entry_steps  (out_ch.entry_steps),
		.last         (out_ch.last)
	);

endmodule

>>> rtl/core/tkri_ctrl.sv
`timescale 1ns / 1ps

module tkri_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tkri_pkg::status_t status,
	output tkri_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// handshakes follow the state
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign cmd.ins   = in_valid && in_ready;
	assign cmd.adv   = out_valid && out_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && status.last) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> rtl/core/tkri_dp.sv
`timescale 1ns / 1ps

module tkri_dp #(
	parameter int LIST_DEPTH = tkri_pkg::LIST_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tkri_pkg::cmd_t               cmd,
	output tkri_pkg::status_t            status,
	input  logic [tkri_pkg::ID_W-1:0]    player_id,
	input  logic [tkri_pkg::PTS_W-1:0]   points,
	input  logic [tkri_pkg::STP_W-1:0]   steps,
	output logic [tkri_pkg::RANK_W-1:0]  rank,
	output logic [tkri_pkg::ID_W-1:0]    entry_id,
	output logic [tkri_pkg::PTS_W-1:0]   entry_points,
	output logic [tkri_pkg::STP_W-1:0]   entry_steps,
	output logic                         last
);

	localparam int FW = $clog2(LIST_DEPTH + 1);
	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	tkri_pkg::entry_t entry_q [LIST_DEPTH];
	logic [FW-1:0]    fill_q;
	logic [IW-1:0]    rank_q;
	logic [LIST_DEPTH-1:0] hit;
	tkri_pkg::entry_t new_entry;

	assign new_entry = '{id: player_id, pts: points, stp: steps};

	// per cell: empty, or strictly beaten by the new entry
	genvar k;
	generate
		for (k = 0; k < LIST_DEPTH; k++) begin : g_cell
			logic             valid_c;
			logic             beats_c;
			logic             first_hit;
			tkri_pkg::entry_t ins_nxt;
			tkri_pkg::entry_t rot_nxt;

			assign valid_c = (FW'(k) < fill_q);
			assign beats_c = {points, steps} > {entry_q[k].pts, entry_q[k].stp};
			assign hit[k]  = !valid_c || beats_c;

			// insert: keep above the slot, place at it, shift down below it
			if (k == 0) begin : g_head
				assign first_hit = hit[0];
				assign ins_nxt   = hit[0] ? new_entry : entry_q[0];
			end else begin : g_body
				assign first_hit = hit[k] && !hit[k-1];
				assign ins_nxt   = first_hit ? new_entry :
					(hit[k] ? entry_q[k-1] : entry_q[k]);
			end

			// listing: rotate the occupied prefix up by one, head wraps to the tail
			if (k == LIST_DEPTH - 1) begin : g_tail
				assign rot_nxt = entry_q[0];
			end else begin : g_mid
				assign rot_nxt = (FW'(k + 1) < fill_q) ? entry_q[k+1] : entry_q[0];
			end

			always_ff @(posedge clk) begin
				if (cmd.ins) begin
					entry_q[k] <= ins_nxt;
				end else if (cmd.adv) begin
					entry_q[k] <= rot_nxt;
				end
			end
		end
	endgenerate

	// fill count and listing rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rank_q <= '0;
		end else begin
			if (cmd.ins) begin
				rank_q <= '0;
				if (fill_q != FW'(LIST_DEPTH)) fill_q <= fill_q + FW'(1);
			end else if (cmd.adv) begin
				rank_q <= rank_q + IW'(1);
			end
		end
	end

	// listing output always comes from the head cell
	assign last         = ((FW'(rank_q) + FW'(1)) == fill_q);
	assign status.last  = last;
	assign rank         = tkri_pkg::RANK_W'(rank_q);
	assign entry_id     = entry_q[0].id;
	assign entry_points = entry_q[0].pts;
	assign entry_steps  = entry_q[0].stp;

endmodule
